[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions used by the block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active-low reset)
`define CHK_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Clocked assertion that also holds through reset
`define CHK_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/rpsr_pkg.sv]
// ----------------------------------------------------------------------------
// rpsr_pkg
// Shared types, widths and register codes of the RC pulse to step rate block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpsr_pkg;

    // Field widths
    localparam int PULSE_W   = 16;
    localparam int TIME_W    = 16;
    localparam int POLE_W    = 7;
    localparam int STEP_W    = 21;
    localparam int PROD_W    = PULSE_W + TIME_W;   // offset * time fraction

    // APB side
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Largest pole pair count the register can hold
    localparam int POLE_MAX = (1 << POLE_W) - 1;

    // Default sine table size
    localparam int SINE_STEPS_DEF = 256;

    // Classified-item queue depth
    localparam int QUEUE_DEPTH = 2;

    // Reset values of the registers
    localparam logic [PULSE_W-1:0] CENTER_RST = 16'd1500;
    localparam logic [PULSE_W-1:0] DEAD_RST   = 16'd20;
    localparam logic [PULSE_W-1:0] UPPER_RST  = 16'd2000;
    localparam logic [PULSE_W-1:0] LOWER_RST  = 16'd1000;
    localparam logic               REV_RST    = 1'b0;
    localparam logic [POLE_W-1:0]  POLE_RST   = 7'd7;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_CENTER  = 3'd0,
        REG_DEAD    = 3'd1,
        REG_UPPER   = 3'd2,
        REG_LOWER   = 3'd3,
        REG_REVERSE = 3'd4,
        REG_POLE    = 3'd5
    } t_reg_idx;

    // Settings the front end classifies with
    typedef struct packed {
        logic [PULSE_W-1:0] center;
        logic [PULSE_W-1:0] dead;
        logic [PULSE_W-1:0] upper;
        logic [PULSE_W-1:0] lower;
        logic               rev;
    } t_front_cfg;

    // One classified item handed from front to back
    typedef struct packed {
        logic [PULSE_W-1:0] num_mag;   // |offset from center| after clamp
        logic [PULSE_W-1:0] den_mag;   // |threshold - center|
        logic [TIME_W-1:0]  time_frac; // Q0.16 seconds
        logic               neg;       // result sign
        logic               zero;      // result forced to zero
    } t_item;

    // Queue handshake toward the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

endpackage

[sv/rc_pulse_to_step_rate_top.sv]
// ----------------------------------------------------------------------------
// rc_pulse_to_step_rate_top
// RC stick pulse to proportional motor step count, with APB settings.
// ----------------------------------------------------------------------------
// Each item (pulse width, Q0.16 time fraction) gives exactly one signed step
// count. The front end classifies an item in the cycle it is accepted and
// places it in a two-entry queue; the back end takes one item at a time
// through two multiply steps, a bit-serial divider and an output register.
// The divider gives QW = clog2(127 * 2 * SINE_STEPS + 1) quotient bits, one
// bit per divide step. Two further items are taken while one is in work,
// and results wait in the output register while the sink stalls.
// Settings sit at byte addresses 4 * index and must be written while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc_pulse_to_step_rate_top #(
    parameter int SINE_STEPS = rpsr_pkg::SINE_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB settings port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rpsr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rpsr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rpsr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rpsr_pkg::PULSE_W-1:0]        i_pulse_width,
    input  logic [rpsr_pkg::TIME_W-1:0]         i_time_fraction,
    // Result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rpsr_pkg::STEP_W-1:0]         o_step_delta
);

    localparam int PW = rpsr_pkg::PULSE_W;
    localparam int DW = rpsr_pkg::APB_DATA_W;

    logic [PW-1:0]                   r_center;
    logic [PW-1:0]                   r_dead;
    logic [PW-1:0]                   r_upper;
    logic [PW-1:0]                   r_lower;
    logic                            r_rev;
    logic [rpsr_pkg::POLE_W-1:0]     r_pole;

    logic                            w_wr;
    logic [2:0]                      w_idx;
    rpsr_pkg::t_front_cfg            w_cfg;
    rpsr_pkg::t_item                 w_item;
    logic                            w_push;
    logic                            w_full;
    logic                            w_pop;
    rpsr_pkg::t_queue_out            w_head;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[4:2];

    // Setting registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= rpsr_pkg::CENTER_RST;
            r_dead   <= rpsr_pkg::DEAD_RST;
            r_upper  <= rpsr_pkg::UPPER_RST;
            r_lower  <= rpsr_pkg::LOWER_RST;
            r_rev    <= rpsr_pkg::REV_RST;
            r_pole   <= rpsr_pkg::POLE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                rpsr_pkg::REG_CENTER:  r_center <= pwdata[PW-1:0];
                rpsr_pkg::REG_DEAD:    r_dead   <= pwdata[PW-1:0];
                rpsr_pkg::REG_UPPER:   r_upper  <= pwdata[PW-1:0];
                rpsr_pkg::REG_LOWER:   r_lower  <= pwdata[PW-1:0];
                rpsr_pkg::REG_REVERSE: r_rev    <= pwdata[0];
                rpsr_pkg::REG_POLE:    r_pole   <= pwdata[rpsr_pkg::POLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (w_idx)
            rpsr_pkg::REG_CENTER:  prdata = DW'(r_center);
            rpsr_pkg::REG_DEAD:    prdata = DW'(r_dead);
            rpsr_pkg::REG_UPPER:   prdata = DW'(r_upper);
            rpsr_pkg::REG_LOWER:   prdata = DW'(r_lower);
            rpsr_pkg::REG_REVERSE: prdata = DW'(r_rev);
            rpsr_pkg::REG_POLE:    prdata = DW'(r_pole);
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        w_cfg.center = r_center;
        w_cfg.dead   = r_dead;
        w_cfg.upper  = r_upper;
        w_cfg.lower  = r_lower;
        w_cfg.rev    = r_rev;
    end

    rpsr_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pulse_width   (i_pulse_width),
        .i_time_fraction (i_time_fraction),
        .i_cfg           (w_cfg),
        .i_queue_full    (w_full),
        .o_push          (w_push),
        .o_item          (w_item)
    );

    rpsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    rpsr_back #(
        .SINE_STEPS (SINE_STEPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_pole_pairs (r_pole),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_step_delta (o_step_delta)
    );

endmodule

[sv/rpsr_front.sv]
// ----------------------------------------------------------------------------
// rpsr_front
// Accepts pulse items, classifies them against the dead band and thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpsr_front (
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rpsr_pkg::PULSE_W-1:0]        i_pulse_width,
    input  logic [rpsr_pkg::TIME_W-1:0]         i_time_fraction,
    input  rpsr_pkg::t_front_cfg                i_cfg,
    input  logic                                i_queue_full,
    output logic                                o_push,
    output rpsr_pkg::t_item                     o_item
);

    localparam int PW = rpsr_pkg::PULSE_W;

    // Magnitude of a 17-bit two's complement value that lies within +-65535
    function automatic logic [PW-1:0] abs17(input logic [PW:0] x);
        logic [PW:0] neg_x;
        neg_x = -x;
        return x[PW] ? neg_x[PW-1:0] : x[PW-1:0];
    endfunction

    logic [PW:0]          w_hi_edge;
    logic signed [PW+1:0] w_lo_edge;
    logic                 w_p_nz;
    logic                 w_above;
    logic                 w_below;
    logic [PW-1:0]        w_p_hi;
    logic [PW-1:0]        w_p_lo;
    logic [PW:0]          w_num;
    logic [PW:0]          w_den;

    // Band edges, computed without wrap
    assign w_hi_edge = {1'b0, i_cfg.center} + {1'b0, i_cfg.dead};
    assign w_lo_edge = $signed({2'b00, i_cfg.center}) - $signed({2'b00, i_cfg.dead});

    // Side of center
    assign w_p_nz  = (i_pulse_width != '0);
    assign w_above = w_p_nz && ({1'b0, i_pulse_width} > w_hi_edge);
    assign w_below = w_p_nz && !w_above &&
                     ($signed({2'b00, i_pulse_width}) < w_lo_edge);

    // Clamp to the threshold on each side
    assign w_p_hi = (i_pulse_width > i_cfg.upper) ? i_cfg.upper : i_pulse_width;
    assign w_p_lo = (i_pulse_width < i_cfg.lower) ? i_cfg.lower : i_pulse_width;

    // Offset and span, same sign on either side
    assign w_num = w_above ? ({1'b0, w_p_hi} - {1'b0, i_cfg.center})
                           : ({1'b0, i_cfg.center} - {1'b0, w_p_lo});
    assign w_den = w_above ? ({1'b0, i_cfg.upper} - {1'b0, i_cfg.center})
                           : ({1'b0, i_cfg.center} - {1'b0, i_cfg.lower});

    // Classified item
    always_comb begin
        o_item.num_mag   = abs17(w_num);
        o_item.den_mag   = abs17(w_den);
        o_item.time_frac = i_time_fraction;
        o_item.neg       = w_below ^ i_cfg.rev;
        o_item.zero      = !(w_above || w_below) || (w_den == '0);
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

endmodule

[sv/rpsr_queue.sv]
// ----------------------------------------------------------------------------
// rpsr_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpsr_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rpsr_pkg::t_item       i_item,
    output logic                  o_full,
    input  logic                  i_pop,
    output rpsr_pkg::t_queue_out  o_head
);

    localparam int DEPTH = rpsr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rpsr_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && (r_count != '0);

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_do_push, w_do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

[sv/rpsr_back.sv]
// ----------------------------------------------------------------------------
// rpsr_back
// Scales a classified item and divides by the span, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpsr_back #(
    parameter int SINE_STEPS = rpsr_pkg::SINE_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rpsr_pkg::t_queue_out              i_head,
    output logic                              o_pop,
    input  logic [rpsr_pkg::POLE_W-1:0]       i_pole_pairs,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rpsr_pkg::STEP_W-1:0]       o_step_delta
);

    localparam int PW   = rpsr_pkg::PULSE_W;
    localparam int OW   = rpsr_pkg::STEP_W;
    localparam int MW   = rpsr_pkg::PROD_W;
    // Quotient bits: the quotient stays below pole_pairs * 2 * SINE_STEPS
    localparam int QW   = $clog2(rpsr_pkg::POLE_MAX * 2 * SINE_STEPS + 1);
    localparam int FW   = QW + MW;              // full product width
    localparam int CW   = $clog2(QW);
    localparam int TWO_SINE = 2 * SINE_STEPS;
    localparam int TIME_W_OFS = rpsr_pkg::TIME_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL1 = 5'b00010,
        ST_MUL2 = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    rpsr_pkg::t_item  r_item, n_item;
    logic [QW-1:0]    r_k, n_k;
    logic [MW-1:0]    r_q, n_q;
    logic [PW-1:0]    r_rem, n_rem;
    logic [QW-1:0]    r_quot, n_quot;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [OW-1:0]    r_out_data, n_out_data;

    logic [FW-1:0]    w_prod;
    logic [PW:0]      w_trial;
    logic [PW:0]      w_diff;
    logic             w_ge;
    logic [OW-1:0]    w_mag;
    logic             w_out_free;

    // Scale product: (pole_pairs * 2 * SINE_STEPS) * (offset * time)
    assign w_prod = FW'(r_k) * FW'(r_q);

    // One restoring division step
    assign w_trial = {r_rem, r_quot[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_item.den_mag};
    assign w_ge    = (w_trial >= {1'b0, r_item.den_mag});

    assign w_mag      = OW'(r_quot);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = (r_state == ST_IDLE) && i_head.valid;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_k         = r_k;
        n_q         = r_q;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_item  = i_head.item;
                    n_k     = QW'(i_pole_pairs) * QW'(TWO_SINE);
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                n_q     = MW'(r_item.num_mag) * MW'(r_item.time_frac);
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                // Drop the Q0.16 fraction bits; upper part starts below the span
                n_rem   = w_prod[FW-1 -: PW];
                n_quot  = w_prod[TIME_W_OFS +: QW];
                n_cnt   = CW'(QW - 1);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem  = w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
                n_quot = {r_quot[QW-2:0], w_ge};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_item.zero) begin
                        n_out_data = '0;
                    end else if (r_item.neg) begin
                        n_out_data = -w_mag;
                    end else begin
                        n_out_data = w_mag;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_k        <= n_k;
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_quot     <= n_quot;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

    assign o_out_valid  = r_out_valid;
    assign o_step_delta = r_out_data;

endmodule

[sv/rpsr_checker.sv]
// ----------------------------------------------------------------------------
// rpsr_checker
// Port-level checks of the RC pulse to step rate block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpsr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rpsr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rpsr_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [rpsr_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                                pready,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [rpsr_pkg::STEP_W-1:0]         o_step_delta
);

    localparam int DW = rpsr_pkg::APB_DATA_W;

    logic w_rev_wr;
    logic w_rev_rd;

    assign w_rev_wr = psel && penable && pwrite && pready &&
                      (paddr[4:2] == rpsr_pkg::REG_REVERSE);
    assign w_rev_rd = psel && !pwrite && (paddr[4:2] == rpsr_pkg::REG_REVERSE);

    // A stalled result stays put
    `CHK_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_step_delta), "stalled result changed")

    // Reset empties the block: no result pending, input open
    `CHK_ANY(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "block not empty after reset")

    // Direction setting reads back what was written
    `CHK_RST(a_rev_readback, i_clk, i_rst_n, w_rev_wr |=> !w_rev_rd || (prdata == DW'($past(pwdata[0]))), "direction read-back mismatch")

endmodule

bind rc_pulse_to_step_rate_top rpsr_checker u_rpsr_checker (.*);

[sim/rpsr_step_checker.sv]
// ----------------------------------------------------------------------------
// rpsr_step_checker
// Predicts and checks the step counts of the RC pulse to step rate block.
// ----------------------------------------------------------------------------
// Watches the settings port, the input item channel and the result channel.
// A register copy follows every settings write, and read data is compared
// with that copy. Every accepted input item queues its predicted step count;
// every accepted result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpsr_step_checker
    import rpsr_pkg::*;
#(
    parameter int SINE_STEPS = SINE_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // settings port
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic [APB_DATA_W-1:0] i_prdata,
    input  logic                  i_pready,
    // input items
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [PULSE_W-1:0]    i_pulse_width,
    input  logic [TIME_W-1:0]     i_time_fraction,
    // result items
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [STEP_W-1:0]     i_step_delta,
    // status toward the testbench top
    output int                    o_fail_cnt,
    output int                    o_pending
);

    // register copy
    logic [PULSE_W-1:0] cfg_center;
    logic [PULSE_W-1:0] cfg_dead;
    logic [PULSE_W-1:0] cfg_upper;
    logic [PULSE_W-1:0] cfg_lower;
    logic               cfg_rev;
    logic [POLE_W-1:0]  cfg_pole;

    // predicted step counts, oldest first
    logic [STEP_W-1:0]  steps_due [$];

    // Step count for one pulse under the current settings
    function automatic logic [STEP_W-1:0] calc_steps(input logic [PULSE_W-1:0] pw,
                                                     input logic [TIME_W-1:0] tf);
        longint            p;
        longint            c;
        longint            d;
        longint            num;
        longint            den;
        longint unsigned   an;
        longint unsigned   ad;
        longint unsigned   prod;
        longint unsigned   mag;
        bit                neg;
        longint            res;
        p   = pw;
        c   = cfg_center;
        d   = cfg_dead;
        num = 0;
        den = 0;
        neg = 1'b0;
        res = 0;
        // zero pulse and the dead band give no motion; band edges may go below 0
        if (p != 0 && !(p <= c + d && p >= c - d)) begin
            if (p > c + d) begin
                if (p > longint'(cfg_upper)) p = cfg_upper;
                num = p - c;
                den = longint'(cfg_upper) - c;
                neg = 1'b0;
            end else begin
                if (p < longint'(cfg_lower)) p = cfg_lower;
                num = c - p;
                den = c - longint'(cfg_lower);
                neg = 1'b1;
            end
            // threshold on center means zero span: no motion
            if (den != 0) begin
                an   = (num < 0) ? -num : num;
                ad   = (den < 0) ? -den : den;
                prod = longint'(cfg_pole) * longint'(SINE_STEPS) * 2 * an * longint'(tf);
                mag  = prod / (ad * 65536);
                if (cfg_rev) neg = !neg;
                res  = neg ? -longint'(mag) : longint'(mag);
            end
        end
        return res[STEP_W-1:0];
    endfunction

    // Register value as a read should return it
    function automatic logic [APB_DATA_W-1:0] cfg_read(input t_reg_idx idx);
        case (idx)
            REG_CENTER:  return APB_DATA_W'(cfg_center);
            REG_DEAD:    return APB_DATA_W'(cfg_dead);
            REG_UPPER:   return APB_DATA_W'(cfg_upper);
            REG_LOWER:   return APB_DATA_W'(cfg_lower);
            REG_REVERSE: return APB_DATA_W'(cfg_rev);
            REG_POLE:    return APB_DATA_W'(cfg_pole);
            default:     return '0;
        endcase
    endfunction

    task automatic note_fail(input string what, input longint want, input longint got);
        o_fail_cnt++;
        if (o_fail_cnt <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endtask

    // Follow settings, queue predictions, compare results
    always @(posedge i_clk) begin
        t_reg_idx          ridx;
        logic [STEP_W-1:0] want;
        ridx = t_reg_idx'(i_paddr[APB_ADDR_W-1:2]);
        if (!i_rst_n) begin
            cfg_center = CENTER_RST;
            cfg_dead   = DEAD_RST;
            cfg_upper  = UPPER_RST;
            cfg_lower  = LOWER_RST;
            cfg_rev    = REV_RST;
            cfg_pole   = POLE_RST;
            steps_due.delete();
        end else begin
            // settings access phase
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (ridx)
                        REG_CENTER:  cfg_center = i_pwdata[PULSE_W-1:0];
                        REG_DEAD:    cfg_dead   = i_pwdata[PULSE_W-1:0];
                        REG_UPPER:   cfg_upper  = i_pwdata[PULSE_W-1:0];
                        REG_LOWER:   cfg_lower  = i_pwdata[PULSE_W-1:0];
                        REG_REVERSE: cfg_rev    = i_pwdata[0];
                        REG_POLE:    cfg_pole   = i_pwdata[POLE_W-1:0];
                        default: ;
                    endcase
                end else if (i_prdata !== cfg_read(ridx)) begin
                    note_fail("register read", cfg_read(ridx), i_prdata);
                end
            end
            // input item accepted
            if (i_in_valid && !i_in_stall)
                steps_due.push_back(calc_steps(i_pulse_width, i_time_fraction));
            // result item accepted
            if (i_out_valid && !i_out_stall) begin
                if (steps_due.size() == 0) begin
                    note_fail("unexpected step_delta", 0, i_step_delta);
                end else begin
                    want = steps_due.pop_front();
                    if (want !== i_step_delta)
                        note_fail("step_delta", want, i_step_delta);
                end
            end
        end
        o_pending = steps_due.size();
    end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench top for the RC pulse to step rate block.
// ----------------------------------------------------------------------------
// Drives a directed set of pulses around the default settings, then random
// pulses over ten settings phases (defaults, reversed direction, field
// extremes, wrong-side thresholds, zero span, zero pole pairs, random sets).
// Both channels idle at random, with one phase free of idling. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rpsr_pkg::*;

    localparam int PHASES     = 10;
    localparam int RAND_ITEMS = 110;
    localparam int STUCK_MAX  = 5000;
    localparam int TAIL_CYC   = 40;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [APB_DATA_W-1:0] pwdata          = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [PULSE_W-1:0]    i_pulse_width   = '0;
    logic [TIME_W-1:0]     i_time_fraction = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic [STEP_W-1:0]     o_step_delta;

    int                    fail_cnt;
    int                    pending;
    int                    stuck_cnt       = 0;
    bit                    quiet           = 1'b0;

    // settings last written, used to aim pulses at the interesting points
    logic [PULSE_W-1:0]    st_center       = CENTER_RST;
    logic [PULSE_W-1:0]    st_dead         = DEAD_RST;
    logic [PULSE_W-1:0]    st_upper        = UPPER_RST;
    logic [PULSE_W-1:0]    st_lower        = LOWER_RST;
    logic                  st_rev          = REV_RST;
    logic [POLE_W-1:0]     st_pole         = POLE_RST;

    rc_pulse_to_step_rate_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pulse_width   (i_pulse_width),
        .i_time_fraction (i_time_fraction),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_step_delta    (o_step_delta)
    );

    rpsr_step_checker i_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_pulse_width   (i_pulse_width),
        .i_time_fraction (i_time_fraction),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_step_delta    (o_step_delta),
        .o_fail_cnt      (fail_cnt),
        .o_pending       (pending)
    );

    always #5 i_clk = ~i_clk;

    // Result side stalls about a third of the time unless quiet
    always @(negedge i_clk) begin
        i_out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 33);
    end

    // Watchdog: cycles with no handshake and no settings access
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cnt <= 0;
        end else begin
            stuck_cnt <= stuck_cnt + 1;
            if (stuck_cnt >= STUCK_MAX) begin
                $display("[rc_pulse_to_step_rate_top] ERROR");
                $finish;
            end
        end
    end

    function automatic logic [PULSE_W-1:0] clamp16(input int v);
        if (v < 0) return '0;
        if (v > 65535) return 16'hFFFF;
        return PULSE_W'(v);
    endfunction

    // Pulse aimed at band edges, thresholds, the live range, or anywhere
    function automatic logic [PULSE_W-1:0] pick_pulse();
        int lo;
        int hi;
        int jit;
        lo  = (st_lower < st_upper) ? int'(st_lower) : int'(st_upper);
        hi  = (st_lower < st_upper) ? int'(st_upper) : int'(st_lower);
        jit = int'($urandom_range(0, 4)) - 2;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return clamp16(int'(st_center) - int'(st_dead) + jit);
            2:       return clamp16(int'(st_center) + int'(st_dead) + jit);
            3:       return clamp16(int'(st_lower) + jit);
            4:       return clamp16(int'(st_upper) + jit);
            5, 6:    return PULSE_W'($urandom_range(lo, hi));
            default: return PULSE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return TIME_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // One settings access: setup cycle, then access until pready, then a gap
    task automatic apb_xfer(input logic wr, input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one item, holding it until it is taken; valid stays high after
    task automatic send_item(input logic [PULSE_W-1:0] pw, input logic [TIME_W-1:0] tf);
        while (!quiet && $urandom_range(0, 99) < 33) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_pulse_width   <= pw;
        i_time_fraction <= tf;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every predicted result
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        // synchronous reset
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                // directed pulses under the reset settings
                send_item(16'd0,     16'hFFFF);   // no signal
                send_item(16'd1480,  16'hFFFF);   // lower band edge
                send_item(16'd1520,  16'hFFFF);   // upper band edge
                send_item(16'd1479,  16'hFFFF);   // just below the band
                send_item(16'd1521,  16'hFFFF);   // just above the band
                send_item(16'd1500,  16'h1234);   // center
                send_item(16'd2000,  16'hFFFF);   // full forward
                send_item(16'd2001,  16'hFFFF);   // clamps to upper
                send_item(16'hFFFF,  16'hFFFF);   // widest pulse
                send_item(16'd1000,  16'hFFFF);   // full backward
                send_item(16'd999,   16'h8000);   // clamps to lower
                send_item(16'd1,     16'hFFFF);   // narrowest nonzero pulse
                send_item(16'd1750,  16'h0000);   // no time elapsed
                send_item(16'd1750,  16'h0001);
                send_item(16'd1250,  16'h8000);
                send_item(16'd1800,  16'hAAAA);
                send_item(16'd1200,  16'h5555);
            end else begin
                case (ph)
                    1: begin   // defaults, reversed direction
                        st_center = 16'd1500; st_dead  = 16'd20;   st_upper = 16'd2000;
                        st_lower  = 16'd1000; st_rev   = 1'b1;     st_pole  = 7'd7;
                    end
                    2: begin   // wide span, most pole pairs
                        st_center = 16'd0;    st_dead  = 16'd0;    st_upper = 16'hFFFF;
                        st_lower  = 16'd0;    st_rev   = 1'b0;     st_pole  = 7'd127;
                    end
                    3: begin   // thresholds on the wrong side, widest band
                        st_center = 16'hFFFF; st_dead  = 16'hFFFF; st_upper = 16'd0;
                        st_lower  = 16'hFFFF; st_rev   = 1'b1;     st_pole  = 7'd1;
                    end
                    4: begin   // both thresholds on center: zero span
                        st_center = 16'd1500; st_dead  = 16'd0;    st_upper = 16'd1500;
                        st_lower  = 16'd1500; st_rev   = 1'b0;     st_pole  = 7'd64;
                    end
                    5: begin   // swapped thresholds, no pole pairs
                        st_center = 16'd1500; st_dead  = 16'd10;   st_upper = 16'd1000;
                        st_lower  = 16'd2000; st_rev   = 1'b0;     st_pole  = 7'd0;
                    end
                    6: begin   // mid-scale center, near-full span
                        st_center = 16'h8000; st_dead  = 16'd100;  st_upper = 16'hFFFF;
                        st_lower  = 16'd1;    st_rev   = 1'b1;     st_pole  = 7'd127;
                    end
                    default: begin
                        st_center = PULSE_W'($urandom_range(0, 65535));
                        st_dead   = $urandom_range(0, 1) ? PULSE_W'($urandom_range(0, 200))
                                                         : PULSE_W'($urandom_range(0, 65535));
                        st_upper  = PULSE_W'($urandom_range(0, 65535));
                        st_lower  = PULSE_W'($urandom_range(0, 65535));
                        st_rev    = 1'($urandom_range(0, 1));
                        st_pole   = POLE_W'($urandom_range(0, 127));
                    end
                endcase
                apb_xfer(1'b1, REG_CENTER,  32'(st_center));
                apb_xfer(1'b1, REG_DEAD,    32'(st_dead));
                apb_xfer(1'b1, REG_UPPER,   32'(st_upper));
                apb_xfer(1'b1, REG_LOWER,   32'(st_lower));
                apb_xfer(1'b1, REG_REVERSE, 32'(st_rev));
                apb_xfer(1'b1, REG_POLE,    32'(st_pole));
                // read every register back
                for (int r = int'(REG_CENTER); r <= int'(REG_POLE); r++)
                    apb_xfer(1'b0, t_reg_idx'(r), '0);
            end

            // random pulses; one phase runs without any idling
            quiet = (ph == 2);
            for (int k = 0; k < RAND_ITEMS; k++) begin
                if (ph == 6 && k == RAND_ITEMS / 2)
                    drain();
                send_item(pick_pulse(), pick_time());
            end
            drain();
        end

        quiet = 1'b0;
        repeat (TAIL_CYC) @(negedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("[rc_pulse_to_step_rate_top] OK");
        else
            $display("[rc_pulse_to_step_rate_top] ERROR");
        $finish;
    end

endmodule
